### design/fsmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_pkg
// Types and constants shared by the flash save memory controller modules:
// request kinds, command opcodes, status and ID words, modes, states and result type.
// ----------------------------------------------------------------------------
package fsmc_pkg;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_REG  = 2'd1,
		KIND_DMA  = 2'd2,
		KIND_LOAD = 2'd3
	} kind_t;

	localparam logic [7:0] OP_EXEC    = 8'hD2;
	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_ID      = 8'hE1;
	localparam logic [7:0] OP_CHIP    = 8'h3C;
	localparam logic [7:0] OP_PAGE    = 8'h4B;
	localparam logic [7:0] OP_ERASE   = 8'h78;
	localparam logic [7:0] OP_PROG    = 8'hB4;
	localparam logic [7:0] OP_PROG_PG = 8'hA5;
	localparam logic [7:0] OP_READ    = 8'hF0;

	localparam logic [31:0] STATUS_ID    = 32'h1111_8001;
	localparam logic [31:0] STATUS_ERASE = 32'h1111_8008;
	localparam logic [31:0] STATUS_BUSY  = 32'h1111_8004;
	localparam logic [31:0] CHIP_ID      = 32'h00C2_001D;
	localparam logic [31:0] STATUS_ADDR  = 32'h0800_0000;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_ID      = 5'b00010,
		MODE_READ    = 5'b00100,
		MODE_PROGRAM = 5'b01000,
		MODE_ERASE   = 5'b10000
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PROG   = 4'b0010,
		ST_PERASE = 4'b0100,
		ST_CLEAR  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        data_valid;
		logic        command_error;
	} res_t;

endpackage
`default_nettype wire

### design/fsmc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Contents are not reset.
// ----------------------------------------------------------------------------
module fsmc_ram #(
	parameter int ADDR_W = 5
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [31:0]       wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [31:0]       rdata
);

	logic [31:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### design/fsmc_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_out_fifo
// Two-entry result queue between the controller and the output channel, so a
// new request can be taken while a finished result still waits.
// ----------------------------------------------------------------------------
module fsmc_out_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fsmc_pkg::res_t push_data,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_ready,
	output fsmc_pkg::res_t     head
);

	fsmc_pkg::res_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign head      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_pop_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rd_ptr_q != $past(rd_ptr_q))
		else $error("head did not advance after pop");

endmodule
`default_nettype wire

### design/flash_save_memory_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flash_save_memory_controller
// Command-driven flash save store with command writes, register reads, DMA
// word reads and page buffer loads; the array sits in a synchronous RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one result. Command
// writes, register reads, page loads and DMA reads outside read mode are
// answered at once; a DMA read in read mode waits for the registered array
// RAM read data. Execute of a page program, a page erase or a whole-chip
// erase holds off new requests until its sweep ends, the single array write
// port writing one word a cycle. After reset the array is swept to ones,
// during which no request is taken. Both parameters must be powers of two.
module flash_save_memory_controller #(
	parameter int FLASH_BYTES = 131072,
	parameter int PAGE_BYTES  = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] address,
	input  wire logic [31:0] data_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      read_data,
	output logic             data_valid,
	output logic             command_error
);

	localparam int ARRAY_WORDS = FLASH_BYTES / 4;
	localparam int PAGE_WORDS  = PAGE_BYTES / 4;
	localparam int AW_W        = $clog2(ARRAY_WORDS);
	localparam int PW_W        = $clog2(PAGE_WORDS);
	localparam int PG_W        = AW_W - PW_W;

	fsmc_pkg::state_t state_q;
	fsmc_pkg::mode_t  mode_q;
	logic [31:0]      status_q;
	logic [PG_W-1:0]  page_q;
	logic             mark_q;
	logic [AW_W-1:0]  cnt_q;

	logic             rd_pend_s1;
	logic             prog_vld_s1;
	logic [PW_W-1:0]  prog_off_s1;

	logic             accept;
	logic             fifo_full;
	logic             is_cmd;
	logic             is_arr_rd;
	logic             push;
	fsmc_pkg::res_t   push_data;
	fsmc_pkg::res_t   imm_res;
	fsmc_pkg::res_t   head;

	logic [7:0]       op;
	logic             cmd_err;
	fsmc_pkg::mode_t  nmode;
	logic [31:0]      nstatus;
	logic [PG_W-1:0]  npage;
	logic             nmark;
	logic             ex_prog;
	logic             ex_perase;
	logic             ex_clear;

	logic             fl_we;
	logic [AW_W-1:0]  fl_waddr;
	logic [31:0]      fl_wdata;
	logic             fl_re;
	logic [31:0]      fl_rdata;
	logic             pb_we;
	logic             pb_re;
	logic [31:0]      pb_rdata;

	logic             page_last;
	logic             chip_last;

	assign in_ready = (state_q == fsmc_pkg::ST_IDLE) && !rd_pend_s1 && !prog_vld_s1
		&& !fifo_full;
	assign accept    = in_valid && in_ready;
	assign is_cmd    = (kind == fsmc_pkg::KIND_CMD);
	assign is_arr_rd = (kind == fsmc_pkg::KIND_DMA) && (mode_q == fsmc_pkg::MODE_READ);
	assign op        = data_word[31:24];

	assign page_last = (cnt_q[PW_W-1:0] == PW_W'(PAGE_WORDS - 1));
	assign chip_last = (cnt_q == AW_W'(ARRAY_WORDS - 1));

	// command decode
	always_comb begin
		cmd_err   = 1'b0;
		nmode     = mode_q;
		nstatus   = status_q;
		npage     = page_q;
		nmark     = mark_q;
		ex_prog   = 1'b0;
		ex_perase = 1'b0;
		ex_clear  = 1'b0;
		case (op)
			fsmc_pkg::OP_EXEC: begin
				nmode = fsmc_pkg::MODE_IDLE;
				if (mode_q == fsmc_pkg::MODE_PROGRAM && !mark_q) begin
					ex_prog = 1'b1;
				end
				if (mode_q == fsmc_pkg::MODE_ERASE) begin
					ex_clear  = mark_q;
					ex_perase = !mark_q;
				end
			end
			fsmc_pkg::OP_NOP: begin
				nmode = mode_q;
			end
			fsmc_pkg::OP_ID: begin
				nmode   = fsmc_pkg::MODE_ID;
				nstatus = fsmc_pkg::STATUS_ID;
			end
			fsmc_pkg::OP_CHIP: begin
				nmark = 1'b1;
			end
			fsmc_pkg::OP_PAGE: begin
				npage = data_word[PG_W-1:0];
				nmark = 1'b0;
			end
			fsmc_pkg::OP_ERASE: begin
				nmode   = fsmc_pkg::MODE_ERASE;
				nstatus = fsmc_pkg::STATUS_ERASE;
			end
			fsmc_pkg::OP_PROG: begin
				nmode = fsmc_pkg::MODE_PROGRAM;
			end
			fsmc_pkg::OP_PROG_PG: begin
				nmode   = fsmc_pkg::MODE_PROGRAM;
				npage   = data_word[PG_W-1:0];
				nmark   = 1'b0;
				nstatus = fsmc_pkg::STATUS_BUSY;
			end
			fsmc_pkg::OP_READ: begin
				nmode   = fsmc_pkg::MODE_READ;
				nstatus = fsmc_pkg::STATUS_BUSY;
			end
			default: begin
				cmd_err = 1'b1;
			end
		endcase
		if (data_word == 32'd0) begin
			nstatus = 32'd0;
		end
	end

	// immediate result
	always_comb begin
		imm_res = '0;
		case (kind)
			fsmc_pkg::KIND_CMD: begin
				imm_res.command_error = cmd_err;
			end
			fsmc_pkg::KIND_REG: begin
				imm_res.data_valid = 1'b1;
				if (address == fsmc_pkg::STATUS_ADDR) begin
					imm_res.read_data = status_q;
				end else begin
					imm_res.read_data = {address[15:0], address[15:0]};
				end
			end
			fsmc_pkg::KIND_DMA: begin
				if (mode_q == fsmc_pkg::MODE_ID) begin
					if (address[31:2] == 30'd0) begin
						imm_res.read_data  = status_q;
						imm_res.data_valid = 1'b1;
					end else if (address[31:2] == 30'd1) begin
						imm_res.read_data  = fsmc_pkg::CHIP_ID;
						imm_res.data_valid = 1'b1;
					end
				end
			end
			default: begin
				imm_res = '0;
			end
		endcase
	end

	assign push = (accept && !is_arr_rd) || rd_pend_s1;

	always_comb begin
		if (rd_pend_s1) begin
			push_data.read_data     = fl_rdata;
			push_data.data_valid    = 1'b1;
			push_data.command_error = 1'b0;
		end else begin
			push_data = imm_res;
		end
	end

	// array write port: clearing sweep, page erase, page program
	always_comb begin
		fl_we    = 1'b0;
		fl_waddr = cnt_q;
		fl_wdata = '1;
		if (state_q == fsmc_pkg::ST_CLEAR) begin
			fl_we = 1'b1;
		end else if (state_q == fsmc_pkg::ST_PERASE) begin
			fl_we    = 1'b1;
			fl_waddr = {page_q, cnt_q[PW_W-1:0]};
		end else if (prog_vld_s1) begin
			fl_we    = 1'b1;
			fl_waddr = {page_q, prog_off_s1};
			fl_wdata = pb_rdata;
		end
	end

	assign fl_re = accept && is_arr_rd;
	assign pb_we = accept && (kind == fsmc_pkg::KIND_LOAD);
	assign pb_re = (state_q == fsmc_pkg::ST_PROG);

	fsmc_ram #(
		.ADDR_W(AW_W)
	) u_array (
		.clk  (clk),
		.we   (fl_we),
		.waddr(fl_waddr),
		.wdata(fl_wdata),
		.re   (fl_re),
		.raddr(address[AW_W+1:2]),
		.rdata(fl_rdata)
	);

	fsmc_ram #(
		.ADDR_W(PW_W)
	) u_page_buf (
		.clk  (clk),
		.we   (pb_we),
		.waddr(address[PW_W-1:0]),
		.wdata(data_word),
		.re   (pb_re),
		.raddr(cnt_q[PW_W-1:0]),
		.rdata(pb_rdata)
	);

	fsmc_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (fifo_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign read_data     = head.read_data;
	assign data_valid    = head.data_valid;
	assign command_error = head.command_error;

	always_ff @(posedge clk) begin
		prog_off_s1 <= cnt_q[PW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsmc_pkg::ST_CLEAR;
			cnt_q       <= '0;
			mode_q      <= fsmc_pkg::MODE_IDLE;
			status_q    <= '0;
			page_q      <= '0;
			mark_q      <= 1'b0;
			rd_pend_s1  <= 1'b0;
			prog_vld_s1 <= 1'b0;
		end else begin
			rd_pend_s1  <= fl_re;
			prog_vld_s1 <= (state_q == fsmc_pkg::ST_PROG);
			if (accept && is_cmd && !cmd_err) begin
				mode_q   <= nmode;
				status_q <= nstatus;
				page_q   <= npage;
				mark_q   <= nmark;
			end
			case (state_q)
				fsmc_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept && is_cmd && ex_prog) begin
						state_q <= fsmc_pkg::ST_PROG;
					end else if (accept && is_cmd && ex_perase) begin
						state_q <= fsmc_pkg::ST_PERASE;
					end else if (accept && is_cmd && ex_clear) begin
						state_q <= fsmc_pkg::ST_CLEAR;
					end
				end
				fsmc_pkg::ST_PROG, fsmc_pkg::ST_PERASE: begin
					cnt_q <= cnt_q + AW_W'(1);
					if (page_last) begin
						state_q <= fsmc_pkg::ST_IDLE;
						cnt_q   <= '0;
					end
				end
				fsmc_pkg::ST_CLEAR: begin
					cnt_q <= cnt_q + AW_W'(1);
					if (chip_last) begin
						state_q <= fsmc_pkg::ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= fsmc_pkg::ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !fl_we)
		else $error("array write during pending array read");

	a_prog_follows_state: assert property (@(posedge clk) disable iff (!arst_n)
		prog_vld_s1 |-> $past(state_q == fsmc_pkg::ST_PROG))
		else $error("program write without program sweep");

	a_arr_rd_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		fl_re |=> push && rd_pend_s1)
		else $error("array read result not queued");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != fsmc_pkg::ST_IDLE) |-> !accept && !pb_we)
		else $error("request taken during array sweep");

endmodule
`default_nettype wire
